@@ hdl/ntea_pkg.sv @@
// Shared types and constants for the neighbour table with ETX ageing.
`default_nettype none
package ntea_pkg;

    localparam int MAX_ENTRIES_DEF = 8;
    localparam int ETX_WINDOW_DEF  = 4;
    localparam int ETX_SCALE_DEF   = 16;
    localparam int METRIC_MAX_DEF  = 255;
    localparam int ADDR_WIDTH_DEF  = 16;
    localparam logic [15:0] LIFETIME_RESET = 16'd120;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_UPM  = 3'd1,
        OP_UPE  = 3'd2,
        OP_TOE  = 3'd3,
        OP_REM  = 3'd4,
        OP_TICK = 3'd5,
        OP_GET  = 3'd6,
        OP_RSVD = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_MODIFY,
        ST_SCAN2,
        ST_OUT
    } fsm_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] neighbor_addr;
        logic [7:0]  metric_in;
        logic [7:0]  etx_sample;
        logic [2:0]  position;
    } ntea_in_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] entry_addr;
        logic [7:0]  entry_metric;
        logic [7:0]  entry_etx;
        logic        best_valid;
        logic [15:0] best_addr;
        logic [8:0]  best_cost;
        logic [3:0]  entry_count;
    } ntea_out_t;

endpackage
`default_nettype wire

@@ hdl/neighbor_table_etx_aging.sv @@
// Neighbour table top level: slot records in one RAM, walked by a sequencer.
// A request is taken only in idle and then passes the first RAM walk, the
// write-back, the second RAM walk and the output load before m_valid; no new
// request is taken until the last result is loaded into the output register.
// Reset: all slots empty, entry count zero, lifetime 120; RAM contents are
// left as they are and only used for occupied slots.
`default_nettype none
module neighbor_table_etx_aging
    import ntea_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ETX_WINDOW  = ETX_WINDOW_DEF,
    parameter int ETX_SCALE   = ETX_SCALE_DEF,
    parameter int METRIC_MAX  = METRIC_MAX_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire ntea_in_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output ntea_out_t        m_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int PTR_W = (ETX_WINDOW > 1) ? $clog2(ETX_WINDOW) : 1;
    localparam int SUM_W = 9 + $clog2(ETX_WINDOW);
    localparam int X_W   = SUM_W + 7;
    localparam int SH    = X_W + 4;
    localparam int M_W   = SH + 1;
    localparam int P_W   = X_W + M_W;
    localparam longint unsigned RECIP = ((64'd1 << SH) + ETX_WINDOW - 1) / ETX_WINDOW;
    localparam int CAP   = METRIC_MAX / ETX_SCALE;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0]        addr;
        logic [7:0]                   metric;
        logic [15:0]                  age;
        logic [PTR_W-1:0]             ptr;
        logic [ETX_WINDOW-1:0][7:0]   ring;
    } rec_t;

    // scaled ring average, division by the window done by reciprocal
    function automatic logic [7:0] etx_of(input logic [ETX_WINDOW-1:0][7:0] ring);
        logic [SUM_W-1:0] sum;
        logic [X_W-1:0]   x;
        logic [P_W-1:0]   prod;
        sum = '0;
        for (int i = 0; i < ETX_WINDOW; i++) begin
            sum = sum + SUM_W'(ring[i]);
        end
        x    = X_W'(sum) * X_W'(ETX_SCALE);
        prod = P_W'(x) * P_W'(RECIP);
        return prod[SH+7:SH];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(ETX_WINDOW - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    rec_t mem [MAX_ENTRIES];
    rec_t rd_data_reg;

    fsm_t state_reg, state_next;
    ntea_in_t req_reg;
    logic [ADDR_WIDTH-1:0] key_reg;
    logic [15:0] lifetime_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0] rank_reg [MAX_ENTRIES];
    logic [CNT_W-1:0] count_reg;

    logic [IDX_W:0]   iss_reg;
    logic             p_vld_reg;
    logic [IDX_W-1:0] p_idx_reg;

    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    rec_t             tgt_rec_reg;
    logic             vic_found_reg;
    logic [IDX_W-1:0] vic_idx_reg;
    logic [IDX_W-1:0] vic_rank_reg;
    logic [7:0]       vic_m_reg, vic_e_reg;
    logic [15:0]      ent_addr_reg;
    logic [7:0]       ent_metric_reg, ent_etx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] tgt_idx_reg;
    logic             best_found_reg;
    logic [8:0]       best_cost_reg;
    logic [15:0]      best_addr_reg;
    logic [IDX_W-1:0] best_rank_reg;
    ntea_out_t        out_reg;
    logic             m_valid_reg;

    logic             rd_en;
    logic             p_slot_ok;
    logic             p_last;
    logic [IDX_W-1:0] sel_idx;
    logic [IDX_W-1:0] sel_rank;
    logic [7:0]       etx_p;
    logic [8:0]       cost_p;
    logic [15:0]      age_inc;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
    rec_t             fill_rec;
    logic             rm_en;
    logic             add_new;
    logic             hit_mod;
    logic             is_match;
    logic             vic_better;
    logic [8:0]       toe_sum;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign rd_en  = ((state_reg == ST_SCAN1) || (state_reg == ST_SCAN2))
                    && (iss_reg < (IDX_W+1)'(MAX_ENTRIES));
    assign p_last = p_vld_reg && (p_idx_reg == IDX_W'(MAX_ENTRIES - 1));

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[iss_reg[IDX_W-1:0]];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        p_slot_ok = p_vld_reg && valid_reg[p_idx_reg];
        sel_idx   = (state_reg == ST_MODIFY) ? match_idx_reg : p_idx_reg;
        sel_rank  = rank_reg[sel_idx];
        etx_p     = etx_of(rd_data_reg.ring);
        cost_p    = 9'(rd_data_reg.metric) + 9'(etx_p);
        age_inc   = rd_data_reg.age + 16'd1;

        free_found = 1'b0;
        free_idx   = '0;
        for (int t = MAX_ENTRIES - 1; t >= 0; t--) begin
            if (!valid_reg[t]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(t);
            end
        end

        if (req_reg.operation == OP_GET) begin
            is_match = (32'(sel_rank) == 32'(req_reg.position))
                       && (32'(req_reg.position) < 32'(count_reg));
        end else begin
            is_match = (rd_data_reg.addr == key_reg);
        end
        vic_better = ({rd_data_reg.metric, etx_p} > {vic_m_reg, vic_e_reg})
                     || (({rd_data_reg.metric, etx_p} == {vic_m_reg, vic_e_reg})
                         && vic_found_reg && (sel_rank < vic_rank_reg));

        fill_rec.addr   = key_reg;
        fill_rec.metric = req_reg.metric_in;
        fill_rec.age    = '0;
        fill_rec.ptr    = '0;
        for (int i = 0; i < ETX_WINDOW; i++) begin
            fill_rec.ring[i] = req_reg.etx_sample;
        end
        toe_sum = 9'(tgt_rec_reg.ring[tgt_rec_reg.ptr]) + 9'(req_reg.etx_sample);

        wr_en   = 1'b0;
        wr_addr = p_idx_reg;
        wr_data = rd_data_reg;
        rm_en   = 1'b0;
        add_new = 1'b0;
        hit_mod = 1'b0;

        if ((state_reg == ST_SCAN1) && (req_reg.operation == OP_TICK) && p_slot_ok
            && (rd_data_reg.age < lifetime_reg)) begin
            wr_en       = 1'b1;
            wr_data.age = age_inc;
            rm_en       = (age_inc == lifetime_reg);
        end

        if (state_reg == ST_MODIFY) begin
            wr_addr = match_idx_reg;
            wr_data = tgt_rec_reg;
            unique case (req_reg.operation)
                OP_ADD: begin
                    wr_data = fill_rec;
                    if (match_found_reg) begin
                        wr_en   = 1'b1;
                        hit_mod = 1'b1;
                    end else if (free_found) begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx;
                        add_new = 1'b1;
                        hit_mod = 1'b1;
                    end else if (vic_found_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = vic_idx_reg;
                        hit_mod = 1'b1;
                    end
                end
                OP_UPM: begin
                    wr_data.metric = req_reg.metric_in;
                    wr_data.age    = '0;
                    wr_en          = match_found_reg;
                    hit_mod        = match_found_reg;
                end
                OP_UPE: begin
                    wr_data.ring[tgt_rec_reg.ptr] = req_reg.etx_sample;
                    wr_data.ptr = ptr_adv(tgt_rec_reg.ptr);
                    wr_data.age = '0;
                    wr_en       = match_found_reg;
                    hit_mod     = match_found_reg;
                end
                OP_TOE: begin
                    // sample accumulates in the current cell, capped
                    wr_data.ring[tgt_rec_reg.ptr] = (toe_sum > 9'(CAP)) ? 8'(CAP)
                                                                        : toe_sum[7:0];
                    wr_data.ptr = ptr_adv(tgt_rec_reg.ptr);
                    wr_en       = match_found_reg;
                    hit_mod     = match_found_reg;
                end
                OP_REM: begin
                    rm_en   = match_found_reg;
                    hit_mod = match_found_reg;
                end
                OP_GET: begin
                    hit_mod = match_found_reg;
                end
                default: begin
                    hit_mod = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SCAN1;
            ST_SCAN1:  if (p_last) state_next = ST_MODIFY;
            ST_MODIFY: state_next = ST_SCAN2;
            ST_SCAN2:  if (p_last) state_next = ST_OUT;
            ST_OUT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            count_reg    <= '0;
            lifetime_reg <= LIFETIME_RESET;
            m_valid_reg  <= 1'b0;
            p_vld_reg    <= 1'b0;
            iss_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                lifetime_reg <= cfg_wr_data;
            end

            if (rm_en) begin
                for (int t = 0; t < MAX_ENTRIES; t++) begin
                    if (valid_reg[t] && (rank_reg[t] > sel_rank)) begin
                        rank_reg[t] <= rank_reg[t] - IDX_W'(1);
                    end
                end
                valid_reg[sel_idx] <= 1'b0;
                count_reg          <= count_reg - CNT_W'(1);
            end else if (add_new) begin
                valid_reg[free_idx] <= 1'b1;
                rank_reg[free_idx]  <= IDX_W'(count_reg);
                count_reg           <= count_reg + CNT_W'(1);
            end

            if ((state_reg == ST_IDLE) || (state_reg == ST_MODIFY)) begin
                iss_reg   <= '0;
                p_vld_reg <= 1'b0;
            end else if (rd_en) begin
                iss_reg   <= iss_reg + (IDX_W+1)'(1);
                p_idx_reg <= iss_reg[IDX_W-1:0];
                p_vld_reg <= 1'b1;
            end else begin
                p_vld_reg <= 1'b0;
            end

            if ((state_reg == ST_OUT) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload side of the sequencer
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                req_reg         <= s_data;
                key_reg         <= ADDR_WIDTH'(64'(s_data.neighbor_addr));
                match_found_reg <= 1'b0;
                match_idx_reg   <= '0;
                vic_found_reg   <= 1'b0;
                vic_m_reg       <= '0;
                vic_e_reg       <= '0;
                best_found_reg  <= 1'b0;
                best_cost_reg   <= 9'(METRIC_MAX);
                best_addr_reg   <= '0;
                ent_addr_reg    <= '0;
                ent_metric_reg  <= '0;
                ent_etx_reg     <= '0;
            end
            ST_SCAN1: begin
                if (p_slot_ok && (req_reg.operation != OP_TICK)) begin
                    if (is_match) begin
                        match_found_reg <= 1'b1;
                        match_idx_reg   <= p_idx_reg;
                        tgt_rec_reg     <= rd_data_reg;
                        ent_addr_reg    <= 16'(64'(rd_data_reg.addr));
                        ent_metric_reg  <= rd_data_reg.metric;
                        ent_etx_reg     <= etx_p;
                    end
                    if (vic_better) begin
                        vic_found_reg <= 1'b1;
                        vic_idx_reg   <= p_idx_reg;
                        vic_rank_reg  <= sel_rank;
                        vic_m_reg     <= rd_data_reg.metric;
                        vic_e_reg     <= etx_p;
                    end
                end
            end
            ST_MODIFY: begin
                hit_reg     <= hit_mod;
                tgt_idx_reg <= wr_addr;
            end
            ST_SCAN2: begin
                if (p_slot_ok) begin
                    if ((cost_p < best_cost_reg)
                        || ((cost_p == best_cost_reg) && best_found_reg
                            && (sel_rank < best_rank_reg))) begin
                        best_found_reg <= 1'b1;
                        best_cost_reg  <= cost_p;
                        best_addr_reg  <= 16'(64'(rd_data_reg.addr));
                        best_rank_reg  <= sel_rank;
                    end
                    if (hit_reg && (req_reg.operation != OP_REM)
                        && (p_idx_reg == tgt_idx_reg)) begin
                        ent_addr_reg   <= 16'(64'(rd_data_reg.addr));
                        ent_metric_reg <= rd_data_reg.metric;
                        ent_etx_reg    <= etx_p;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_reg.hit          <= hit_reg;
                    out_reg.entry_addr   <= hit_reg ? ent_addr_reg : '0;
                    out_reg.entry_metric <= hit_reg ? ent_metric_reg : '0;
                    out_reg.entry_etx    <= hit_reg ? ent_etx_reg : '0;
                    out_reg.best_valid   <= best_found_reg;
                    out_reg.best_addr    <= best_found_reg ? best_addr_reg : '0;
                    out_reg.best_cost    <= best_found_reg ? best_cost_reg : '0;
                    out_reg.entry_count  <= 4'(32'(count_reg));
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ dv/ntea_checker.sv @@
// Checker for the neighbour table: predicts each result and compares it with the block.
`default_nettype none
module ntea_checker
    import ntea_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire ntea_in_t    s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire ntea_out_t   m_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    output int               fail_count,
    output int               pending
);
    localparam int NSLOT = 8;
    localparam int NWIN  = 4;
    localparam int SCALE = 16;
    localparam int MMAX  = 255;

    logic [15:0] life;
    logic        nb_valid [NSLOT];
    logic [15:0] nb_addr  [NSLOT];
    logic [7:0]  nb_metric[NSLOT];
    logic [7:0]  nb_ring  [NSLOT][NWIN];
    int          nb_ptr   [NSLOT];
    int          nb_age   [NSLOT];
    int          nb_rank  [NSLOT];
    int          nb_count;
    ntea_out_t   expected_results[$];

    assign pending = expected_results.size();

    function automatic int slot_of_rank(int r);
        for (int s = 0; s < NSLOT; s++)
            if (nb_valid[s] && nb_rank[s] == r) return s;
        return -1;
    endfunction

    function automatic int lookup(logic [15:0] a);
        int s;
        for (int r = 0; r < nb_count; r++) begin
            s = slot_of_rank(r);
            if (s >= 0 && nb_addr[s] == a) return s;
        end
        return -1;
    endfunction

    function automatic logic [7:0] scaled_etx(int s);
        int sum;
        sum = 0;
        for (int i = 0; i < NWIN; i++) sum += nb_ring[s][i];
        return 8'((SCALE * sum) / NWIN);
    endfunction

    function automatic void drop_slot(int s);
        nb_valid[s] = 1'b0;
        for (int t = 0; t < NSLOT; t++)
            if (nb_valid[t] && nb_rank[t] > nb_rank[s]) nb_rank[t]--;
        if (nb_count > 0) nb_count--;
    endfunction

    function automatic void fill(int s, ntea_in_t d);
        nb_age[s] = 0;
        nb_addr[s] = d.neighbor_addr;
        nb_metric[s] = d.metric_in;
        for (int i = 0; i < NWIN; i++) nb_ring[s][i] = d.etx_sample;
        nb_ptr[s] = 0;
    endfunction

    function automatic ntea_out_t apply_request(ntea_in_t d);
        ntea_out_t o;
        int s, t, r, v, bm, be, bc, b, c;
        o = '0;
        s = -1;
        case (op_t'(d.operation))
            OP_ADD: begin
                s = lookup(d.neighbor_addr);
                if (s < 0)
                    for (t = 0; t < NSLOT; t++)
                        if (!nb_valid[t]) begin
                            s = t;
                            nb_valid[t] = 1'b1;
                            nb_rank[t] = nb_count;
                            nb_count++;
                            break;
                        end
                if (s < 0) begin
                    // full: recycle the worst entry, higher metric then higher ETX
                    bm = 0; be = 0;
                    for (r = 0; r < nb_count; r++) begin
                        t = slot_of_rank(r);
                        if (t < 0) continue;
                        if (nb_metric[t] > bm ||
                            (nb_metric[t] == bm && scaled_etx(t) > be)) begin
                            bm = nb_metric[t]; be = scaled_etx(t); s = t;
                        end
                    end
                end
                if (s >= 0) fill(s, d);
            end
            OP_UPM: begin
                s = lookup(d.neighbor_addr);
                if (s >= 0) begin
                    nb_metric[s] = d.metric_in;
                    nb_age[s] = 0;
                end
            end
            OP_UPE: begin
                s = lookup(d.neighbor_addr);
                if (s >= 0) begin
                    nb_ring[s][nb_ptr[s]] = d.etx_sample;
                    nb_ptr[s] = (nb_ptr[s] + 1) % NWIN;
                    nb_age[s] = 0;
                end
            end
            OP_TOE: begin
                s = lookup(d.neighbor_addr);
                if (s >= 0) begin
                    v = nb_ring[s][nb_ptr[s]] + d.etx_sample;
                    if (v > MMAX / SCALE) v = MMAX / SCALE;
                    nb_ring[s][nb_ptr[s]] = 8'(v);
                    nb_ptr[s] = (nb_ptr[s] + 1) % NWIN;
                end
            end
            OP_REM: begin
                t = lookup(d.neighbor_addr);
                if (t >= 0) begin
                    o.hit = 1'b1;
                    o.entry_addr = nb_addr[t];
                    o.entry_metric = nb_metric[t];
                    o.entry_etx = scaled_etx(t);
                    drop_slot(t);
                end
            end
            OP_TICK: begin
                r = 0;
                while (r < nb_count) begin
                    t = slot_of_rank(r);
                    if (t >= 0 && nb_age[t] < life) begin
                        nb_age[t]++;
                        if (nb_age[t] == life) begin
                            drop_slot(t);
                            continue;
                        end
                    end
                    r++;
                end
            end
            OP_GET: if (d.position < nb_count) s = slot_of_rank(d.position);
            default: ;
        endcase
        if (s >= 0) begin
            o.hit = 1'b1;
            o.entry_addr = nb_addr[s];
            o.entry_metric = nb_metric[s];
            o.entry_etx = scaled_etx(s);
        end
        bc = MMAX; b = -1;
        for (r = 0; r < nb_count; r++) begin
            t = slot_of_rank(r);
            if (t < 0) continue;
            c = nb_metric[t] + scaled_etx(t);
            if (c < bc) begin bc = c; b = t; end
        end
        if (b >= 0) begin
            o.best_valid = 1'b1;
            o.best_addr = nb_addr[b];
            o.best_cost = 9'(bc);
        end
        o.entry_count = 4'(nb_count);
        return o;
    endfunction

    always @(posedge aclk) begin
        ntea_out_t want;
        if (!aresetn) begin
            life <= LIFETIME_RESET;
            nb_count = 0;
            for (int s = 0; s < NSLOT; s++) nb_valid[s] = 1'b0;
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) life <= cfg_wr_data;
            if (s_valid && s_ready) expected_results.push_back(apply_request(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== m_data) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Testbench top: drives requests and lifetime writes, gives the verdict.
`default_nettype none
module tb;
    import ntea_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    ntea_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    ntea_out_t   m_data;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    int          fail_count;
    int          pending;
    bit          quiet;
    logic [15:0] addr_pool[6];

    neighbor_table_etx_aging dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    ntea_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    // result side back-pressure in bursts
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 11);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // valid stays high between back-to-back requests; it drops only for an idle burst
    task automatic send_request(ntea_in_t d);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send(op_t op, logic [15:0] a, logic [7:0] m, logic [7:0] e,
                        logic [2:0] p);
        ntea_in_t d;
        d.operation = op;
        d.neighbor_addr = a;
        d.metric_in = m;
        d.etx_sample = e;
        d.position = p;
        send_request(d);
    endtask

    task automatic drain_and_set_lifetime(logic [15:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_phase(int count, int pool_size);
        ntea_in_t d;
        for (int i = 0; i < count; i++) begin
            d = ntea_in_t'($bits(ntea_in_t)'({$urandom, $urandom}));
            if ($urandom_range(0, 9) != 0)
                d.neighbor_addr = addr_pool[$urandom_range(0, pool_size - 1)]
                                  + 16'($urandom_range(0, 9));
            if ($urandom_range(0, 2) == 0) d.etx_sample = 8'($urandom_range(0, 5));
            if ($urandom_range(0, 7) == 0) d.operation = OP_ADD;
            send_request(d);
        end
    endtask

    initial begin
        quiet = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        for (int i = 0; i < 6; i++) addr_pool[i] = 16'($urandom);
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'hfff6;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fill past capacity, extremes, every operation
        send(OP_GET, 16'h0, 8'h0, 8'h0, 3'd0);
        send(OP_ADD, 16'h0000, 8'h00, 8'h00, 3'd0);
        send(OP_ADD, 16'hffff, 8'hff, 8'hff, 3'd7);
        for (int i = 1; i <= 7; i++) send(OP_ADD, 16'(i), 8'(i * 30), 8'(i), 3'd0);
        send(OP_ADD, 16'h0000, 8'h10, 8'h02, 3'd0);
        send(OP_UPM, 16'h0003, 8'hff, 8'h00, 3'd0);
        send(OP_UPE, 16'h0004, 8'h00, 8'hff, 3'd0);
        send(OP_TOE, 16'h0005, 8'h00, 8'hff, 3'd0);
        send(OP_TOE, 16'h1234, 8'h00, 8'h01, 3'd0);
        send(OP_REM, 16'h0002, 8'h00, 8'h00, 3'd0);
        send(OP_REM, 16'h0002, 8'h00, 8'h00, 3'd0);
        send(OP_GET, 16'h0, 8'h0, 8'h0, 3'd7);
        send(OP_GET, 16'h0, 8'h0, 8'h0, 3'd1);
        send(OP_TICK, 16'h0, 8'h0, 8'h0, 3'd0);
        send(OP_RSVD, 16'hffff, 8'hff, 8'hff, 3'd7);

        // short lifetime: expiry; then lower it below existing ages
        drain_and_set_lifetime(16'd3);
        for (int i = 0; i < 4; i++) send(OP_TICK, 16'h0, 8'h0, 8'h0, 3'd0);
        random_phase(300, 6);
        drain_and_set_lifetime(16'd0);
        random_phase(300, 6);
        drain_and_set_lifetime(16'hffff);
        random_phase(300, 6);
        drain_and_set_lifetime(16'd1);
        random_phase(250, 3);
        drain_and_set_lifetime(16'd12);
        random_phase(300, 6);
        drain_and_set_lifetime(16'd5);
        quiet = 1'b1;
        random_phase(280, 6);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ neighbor_table_etx_aging.f @@
hdl/ntea_pkg.sv
hdl/neighbor_table_etx_aging.sv
dv/ntea_checker.sv
dv/tb.sv
